// ----- rtl/rag_pkg.sv -----
package rag_pkg;

  localparam int AZ_W          = 12;
  localparam int AZIMUTH_COUNT = 4096;
  localparam int MODE_W        = 8;
  localparam int GAP_W         = 6;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 8;

  localparam logic [7:0]           ID_CH0        = 8'd10;
  localparam logic [7:0]           ID_CH1        = 8'd11;
  localparam logic [GAP_W-1:0]     GAP_RESET     = 6'd20;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT = 1'd1;

  typedef struct packed {
    logic [7:0]      packet_id;
    logic [AZ_W-1:0] azimuth;
  } in_t;

  typedef struct packed {
    logic            channel;
    logic [AZ_W-1:0] line_azimuth;
    logic            jumped;
    logic            last_line;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } state_t;

endpackage

// ----- rtl/radar_azimuth_gap_fill_top.sv -----
// Radar azimuth gap fill.
// Input channel (in_valid / in_stall / in_data) takes one packet header:
// packet id and 12-bit azimuth. Ids 10 and 11 select channel 0 and 1; any
// other id is taken and dropped with no result.
// Output channel (out_valid / out_stall / out_data) gives one request per
// display line: channel, line azimuth, jump flag and last-line flag.
// A short step in the scan direction fills every azimuth passed over; any
// other step gives a single line at the new azimuth with the jump flag set.
// A run is cut after MAX_LINES lines.
// Sequence: the packet is accepted, then the step is compared against the
// gap limit, then one line per cycle while the output is not stalled, from a
// single azimuth counter that steps up or down. in_stall is high
// while a packet is in progress.
// A stall on the output holds the output register and freezes the run.
// Reset (rst_n low, synchronous) clears both stored azimuths to 0, sets
// scan_mode to 0 and gap_limit to 20, and empties the output register.
// cfg_we writes cfg_wdata to register cfg_index (0 scan_mode, 1 gap_limit).
module radar_azimuth_gap_fill_top #(
  parameter int MAX_LINES = 40
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rag_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rag_pkg::out_t                       out_data,
  input  logic                                cfg_we,
  input  logic [rag_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rag_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import rag_pkg::*;

  localparam int CNT_W = $clog2(MAX_LINES + 1);

  state_t state_r, state_nxt;

  logic [MODE_W-1:0] scan_mode_r;
  logic [GAP_W-1:0]  gap_r;
  logic [AZ_W-1:0]   prev_r [2];

  logic              ch_r;
  logic [AZ_W-1:0]   cur_r;
  logic [AZ_W-1:0]   az_r;
  logic              down_r;
  logic              jump_r;
  logic [CNT_W-1:0]  cnt_r;

  logic              out_valid_r;
  out_t              out_r;

  logic              in_acc;
  logic              id_ok;
  logic              out_free;

  logic [AZ_W-1:0]   last;
  logic [AZ_W:0]     last_g, cur_g;
  logic [AZ_W-1:0]   d_fwd, d_bwd, d_sel;
  logic              cw, fill, fill_cw, fill_ccw;
  logic [AZ_W-1:0]   n_cap;

  assign in_acc   = in_valid && !in_stall;
  assign id_ok    = (in_data.packet_id == ID_CH0) || (in_data.packet_id == ID_CH1);
  assign out_free = !out_valid_r || !out_stall;

  assign last   = prev_r[ch_r];
  assign last_g = {1'b0, last} + (AZ_W+1)'(gap_r);
  assign cur_g  = {1'b0, cur_r} + (AZ_W+1)'(gap_r);
  assign d_fwd  = cur_r - last;
  assign d_bwd  = last - cur_r;

  always_comb begin
    case (scan_mode_r)
      8'd0, 8'd2, 8'd4: cw = 1'b1;
      default:          cw = 1'b0;
    endcase
  end

  always_comb begin
    fill_cw  = ((cur_r > last) && ({1'b0, cur_r} < last_g)) ||
               ((cur_r < last) && ({{(AZ_W+1-GAP_W){1'b0}}, gap_r} > {1'b0, cur_r}) &&
                (last_g > (AZ_W+1)'(AZIMUTH_COUNT)));
    fill_ccw = ((cur_r < last) && (cur_g > {1'b0, last})) ||
               ((cur_r > last) && (cur_g > (AZ_W+1)'(AZIMUTH_COUNT)) &&
                ({1'b0, last} < {{(AZ_W+1-GAP_W){1'b0}}, gap_r}));
    fill     = cw ? fill_cw : fill_ccw;
    d_sel    = cw ? d_fwd : d_bwd;
    n_cap    = (d_sel > AZ_W'(MAX_LINES)) ? AZ_W'(MAX_LINES) : d_sel;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc && id_ok) state_nxt = ST_CALC;
      ST_CALC: state_nxt = ST_EMIT;
      ST_EMIT: if (out_free && (cnt_r == CNT_W'(1))) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_mode_r <= '0;
      gap_r       <= GAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCAN_MODE: scan_mode_r <= cfg_wdata;
        REG_GAP_LIMIT: gap_r       <= cfg_wdata[GAP_W-1:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r[0] <= '0;
      prev_r[1] <= '0;
    end else if (state_r == ST_CALC) begin
      prev_r[ch_r] <= cur_r;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ch_r  <= (in_data.packet_id == ID_CH1);
          cur_r <= in_data.azimuth;
        end
      end
      ST_CALC: begin
        az_r   <= fill ? last : cur_r;
        down_r <= !cw;
        jump_r <= !fill;
        cnt_r  <= fill ? n_cap[CNT_W-1:0] : CNT_W'(1);
      end
      ST_EMIT: begin
        if (out_free) begin
          az_r  <= down_r ? az_r - AZ_W'(1) : az_r + AZ_W'(1);
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && out_free) begin
      out_r.channel      <= ch_r;
      out_r.line_azimuth <= az_r;
      out_r.jumped       <= jump_r;
      out_r.last_line    <= (cnt_r == CNT_W'(1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- tb/sv/tb_radar_azimuth_gap_fill_top.sv -----
module tb_radar_azimuth_gap_fill_top;
  import rag_pkg::*;

  localparam int LINE_CAP     = 40;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_GAP      = 12;
  localparam int REPORT_LIMIT = 10;

  localparam logic [MODE_W-1:0] MODE_CW0     = 8'd0;
  localparam logic [MODE_W-1:0] MODE_CW2     = 8'd2;
  localparam logic [MODE_W-1:0] MODE_CW4     = 8'd4;
  localparam logic [MODE_W-1:0] MODE_CCW1    = 8'd1;
  localparam logic [MODE_W-1:0] MODE_CCW3    = 8'd3;
  localparam logic [MODE_W-1:0] MODE_CCW_MAX = 8'd255;

  class gap_fill_lines;
    out_t              pending_lines[$];
    logic [MODE_W-1:0] scan_mode;
    logic [GAP_W-1:0]  gap_limit;
    logic [AZ_W-1:0]   last_az[2];
    int unsigned       line_cap;
    int                mismatches;

    function new(int unsigned cap);
      line_cap   = (cap > 64) ? 64 : (cap < 1) ? 1 : cap;
      scan_mode  = MODE_CW0;
      gap_limit  = GAP_RESET;
      last_az[0] = '0;
      last_az[1] = '0;
      mismatches = 0;
    endfunction

    function bit clockwise();
      return scan_mode inside {MODE_CW0, MODE_CW2, MODE_CW4};
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == REG_SCAN_MODE) scan_mode = value[MODE_W-1:0];
      else if (idx == REG_GAP_LIMIT) gap_limit = value[GAP_W-1:0];
    endfunction

    function int pending();
      return pending_lines.size();
    endfunction

    function void note_packet(in_t pkt);
      int unsigned cur, last, g, n;
      bit          fill, down;
      logic        ch;
      out_t        line;
      if (pkt.packet_id == ID_CH0) ch = 1'b0;
      else if (pkt.packet_id == ID_CH1) ch = 1'b1;
      else return;
      cur  = pkt.azimuth;
      last = last_az[ch];
      g    = gap_limit;
      n    = 1;
      fill = 1'b0;
      down = 1'b0;
      if (clockwise()) begin
        if (cur > last && cur < last + g) begin
          n    = cur - last;
          fill = 1'b1;
        end else if (cur < last && cur < g && last + g > AZIMUTH_COUNT) begin
          n    = AZIMUTH_COUNT + cur - last;
          fill = 1'b1;
        end
      end else begin
        if (cur < last && cur + g > last) begin
          n    = last - cur;
          fill = 1'b1;
          down = 1'b1;
        end else if (cur > last && cur + g > AZIMUTH_COUNT && last < g) begin
          n    = AZIMUTH_COUNT + last - cur;
          fill = 1'b1;
          down = 1'b1;
        end
      end
      if (n > line_cap) n = line_cap;
      for (int unsigned i = 0; i < n; i++) begin
        line.channel      = ch;
        line.line_azimuth = !fill ? pkt.azimuth : down ? AZ_W'(last - i) : AZ_W'(last + i);
        line.jumped       = !fill;
        line.last_line    = (i + 1 == n);
        pending_lines.insert(pending_lines.size(), line);
      end
      last_az[ch] = pkt.azimuth;
    endfunction

    function void check_line(out_t got);
      out_t exp_line;
      bit   bad;
      bad = 1'b0;
      if (pending_lines.size() == 0) begin
        exp_line = 'x;
        bad      = 1'b1;
      end else begin
        exp_line = pending_lines[0];
        pending_lines.delete(0);
        bad = (got.channel !== exp_line.channel) ||
              (got.line_azimuth !== exp_line.line_azimuth) ||
              (got.jumped !== exp_line.jumped) ||
              (got.last_line !== exp_line.last_line);
      end
      if (bad) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("exp ch=%0d az=%0d j=%0b l=%0b, got ch=%0d az=%0d j=%0b l=%0b",
                   exp_line.channel, exp_line.line_azimuth, exp_line.jumped,
                   exp_line.last_line, got.channel, got.line_azimuth, got.jumped,
                   got.last_line);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int            tx_idle_pct = 38;
  int            rx_idle_pct = 38;
  bit            hold_off_req = 1'b0;
  gap_fill_lines fill_lines;

  radar_azimuth_gap_fill_top #(
    .MAX_LINES(LINE_CAP)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) fill_lines.check_line(out_data);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  task automatic send_packet(in_t pkt);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct && gap < MAX_GAP) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pkt;
    do @(posedge clk); while (in_stall);
    fill_lines.note_packet(pkt);
  endtask

  task automatic drain_lines();
    in_valid <= 1'b0;
    while (fill_lines.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    drain_lines();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    fill_lines.write_reg(idx, value);
  endtask

  task automatic set_scan(logic [MODE_W-1:0] mode, logic [CFG_DATA_W-1:0] gap);
    set_reg(REG_SCAN_MODE, mode);
    set_reg(REG_GAP_LIMIT, gap);
  endtask

  task automatic run_phase(int count);
    int              counted;
    int              r;
    int              step;
    logic            ch;
    bit              fwd;
    logic [AZ_W-1:0] base;
    in_t             pkt;
    counted = 0;
    while (counted < count) begin
      r = $urandom_range(99);
      if (r < 12) begin
        pkt.packet_id = 8'($urandom());
        pkt.azimuth   = AZ_W'($urandom());
      end else begin
        ch            = 1'($urandom_range(1));
        pkt.packet_id = ch ? ID_CH1 : ID_CH0;
        base          = fill_lines.last_az[ch];
        step          = $urandom_range(fill_lines.gap_limit + 2);
        fwd           = fill_lines.clockwise() ^ ($urandom_range(99) < 15);
        if (r < 20)
          pkt.azimuth = AZ_W'($urandom());
        else if (r < 28)
          pkt.azimuth = $urandom_range(1) ? AZ_W'($urandom_range(40)) :
                                            AZ_W'(AZIMUTH_COUNT - 1 - $urandom_range(40));
        else
          pkt.azimuth = fwd ? base + AZ_W'(step) : base - AZ_W'(step);
      end
      send_packet(pkt);
      counted++;
    end
  endtask

  initial begin
    fill_lines = new(LINE_CAP);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_packet('{ID_CH0, 12'd0});
    send_packet('{ID_CH0, 12'd5});
    send_packet('{8'd0, 12'd100});
    send_packet('{ID_CH1, 12'd4095});
    send_packet('{ID_CH1, 12'd3});
    send_packet('{ID_CH0, 12'd24});
    send_packet('{ID_CH0, 12'd44});
    send_packet('{8'hFF, 12'd4095});

    set_scan(MODE_CCW1, 8'd63);
    send_packet('{ID_CH0, 12'd4});
    send_packet('{ID_CH0, 12'd3});
    send_packet('{ID_CH1, 12'd4090});
    send_packet('{ID_CH1, 12'd4090});
    send_packet('{ID_CH1, 12'd4095});
    send_packet('{ID_CH0, 12'd4050});

    set_scan(MODE_CW4, 8'd0);
    send_packet('{ID_CH0, 12'd4051});
    send_packet('{8'd9, 12'd0});

    set_scan(MODE_CW2, 8'd63);
    send_packet('{ID_CH1, 12'd4060});
    send_packet('{ID_CH1, 12'd30});
    send_packet('{ID_CH1, 12'd92});

    set_scan(MODE_CCW_MAX, 8'd1);
    send_packet('{ID_CH0, 12'd4050});
    send_packet('{8'd12, 12'd2048});

    set_scan(MODE_CCW3, 8'd2);
    send_packet('{ID_CH0, 12'd4049});

    set_scan(MODE_CW0, 8'd20);
    run_phase(60);

    set_scan(MODE_CCW1, 8'd63);
    hold_off_req = 1'b1;
    run_phase(60);

    set_scan(MODE_CW4, 8'd1);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(60);
    tx_idle_pct = 38;
    rx_idle_pct = 38;

    set_scan(MODE_CCW_MAX, 8'hC5);
    run_phase(50);

    set_scan(MODE_CW2, 8'd0);
    run_phase(30);

    set_scan(MODE_CCW3, 8'd32);
    run_phase(60);

    set_scan(MODE_W'($urandom()), CFG_DATA_W'($urandom_range(63)));
    run_phase(38);

    drain_lines();
    if (fill_lines.mismatches == 0 && fill_lines.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
